// File: sv/sgm_pkg.sv
// shared types and constants for the sobel gradient magnitude unit
// no dependencies; used by sgm_grad, the top level and the testbench
`default_nettype none

package sgm_pkg;

  // field widths of the streams
  localparam int PIX_W       = 8;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int GRAD_W      = 11;
  localparam int MAG_W       = 11;
  localparam int OUT_TDATA_W = 72;

  // configuration port
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 1;

  // defaults and limits
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int RESET_WIDTH       = 640;
  localparam int RESET_HEIGHT      = 480;
  localparam int MIN_DIM           = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // 3x3 neighborhood around the centre pixel (centre itself not needed)
  typedef struct packed {
    logic [PIX_W-1:0] top_l;
    logic [PIX_W-1:0] top_c;
    logic [PIX_W-1:0] top_r;
    logic [PIX_W-1:0] mid_l;
    logic [PIX_W-1:0] mid_r;
    logic [PIX_W-1:0] bot_l;
    logic [PIX_W-1:0] bot_c;
    logic [PIX_W-1:0] bot_r;
  } window_t;

  // gradient results of one window
  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]         magnitude;
  } grad_t;

endpackage

`default_nettype wire

// File: sv/sgm_ram.sv
// generic single-port-write, single-port-read memory with registered read
// no dependencies
`default_nettype none

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/sgm_grad.sv
// sobel x/y gradients and shift-add magnitude approximation of one window
// depends on sgm_pkg
`default_nettype none

module sgm_grad (
  input  wire sgm_pkg::window_t win,
  output sgm_pkg::grad_t        grad
);

  localparam int SUM_W = sgm_pkg::PIX_W + 2;
  localparam int WW    = sgm_pkg::GRAD_W + 1;

  logic [SUM_W-1:0]     right_sum, left_sum, bot_sum, top_sum;
  logic signed [WW-1:0] gx, gy;
  logic [WW-1:0]        ax, ay, mn, mag;

  // weighted 1-2-1 column and row sums
  always_comb begin
    right_sum = SUM_W'(win.top_r) + SUM_W'({win.mid_r, 1'b0}) + SUM_W'(win.bot_r);
    left_sum  = SUM_W'(win.top_l) + SUM_W'({win.mid_l, 1'b0}) + SUM_W'(win.bot_l);
    bot_sum   = SUM_W'(win.bot_l) + SUM_W'({win.bot_c, 1'b0}) + SUM_W'(win.bot_r);
    top_sum   = SUM_W'(win.top_l) + SUM_W'({win.top_c, 1'b0}) + SUM_W'(win.top_r);
  end

  // gradients, absolute values and the smaller term
  always_comb begin
    gx  = $signed(WW'(right_sum)) - $signed(WW'(left_sum));
    gy  = $signed(WW'(bot_sum)) - $signed(WW'(top_sum));
    ax  = gx[WW-1] ? WW'(-gx) : WW'(gx);
    ay  = gy[WW-1] ? WW'(-gy) : WW'(gy);
    mn  = (ax < ay) ? ax : ay;
    mag = ax + ay - (mn >> 1) - (mn >> 2) + (mn >> 4);
  end

  assign grad.grad_x    = gx[sgm_pkg::GRAD_W-1:0];
  assign grad.grad_y    = gy[sgm_pkg::GRAD_W-1:0];
  assign grad.magnitude = mag[sgm_pkg::MAG_W-1:0];

endmodule

`default_nettype wire

// File: sv/sobel_gradient_magnitude_unit.sv
// Sobel gradient magnitude unit: takes 8-bit gray pixels in raster order and gives, for
// every interior pixel, its column and row, the Sobel x and y gradients, an approximate
// magnitude |gx|+|gy|-mn/2-mn/4+mn/16 (mn the smaller term) and the running frame maximum.
// Border pixels (first two columns and rows of input) give no output transfer; the last
// interior pixel of a frame carries tlast and clears the maximum. One pixel is taken every
// clock while results drain; a result waiting on m_tready holds its pixel in the input
// register, so the input stalls for as long as the output does. A pixel's result is loaded
// into the output register from the input register once the output is free; the line memory
// that holds the two previous lines is read at the input transfer itself, alongside the
// input register, so its data lines up with the input register. The line memory needs
// no initialization: only lines already written are read.
// image_width is saturated to 3..MAX_WIDTH and image_height to at least 3.
// depends on sgm_pkg, sgm_ram, sgm_grad
`default_nettype none

module sobel_gradient_magnitude_unit #(
  parameter int MAX_WIDTH = sgm_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // pixel stream in; tdata: pixel[7:0]
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [sgm_pkg::PIX_W-1:0]           s_tdata,
  // result stream out; tdata: column[9:0], row[21:10], grad_x[32:22], grad_y[43:33],
  // magnitude[54:44], max_magnitude[65:55], zero fill[71:66]; tlast: frame_last
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [sgm_pkg::OUT_TDATA_W-1:0]          m_tdata,
  output logic                                     m_tlast,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [sgm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMP_W = (CW + 1 > sgm_pkg::WIDTH_CFG_W) ? CW + 1 : sgm_pkg::WIDTH_CFG_W;
  localparam int HW    = sgm_pkg::ROW_W + 1;
  localparam int PW    = sgm_pkg::PIX_W;
  localparam int MW    = sgm_pkg::MAG_W;

  // configuration registers
  logic [sgm_pkg::WIDTH_CFG_W-1:0]  image_width;
  logic [sgm_pkg::HEIGHT_CFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sgm_pkg::WIDTH_CFG_W'(sgm_pkg::RESET_WIDTH);
      image_height <= sgm_pkg::HEIGHT_CFG_W'(sgm_pkg::RESET_HEIGHT);
    end else if (cfg_we) begin
      unique case (sgm_pkg::cfg_reg_t'(cfg_index))
        sgm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[sgm_pkg::WIDTH_CFG_W-1:0];
        sgm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[sgm_pkg::HEIGHT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [CMP_W-1:0] width_ext, eff_w, col_plus;
  logic [HW-1:0]    height_ext, eff_h, row_plus;

  always_comb begin
    width_ext = CMP_W'(image_width);
    if (width_ext < CMP_W'(sgm_pkg::MIN_DIM)) begin
      eff_w = CMP_W'(sgm_pkg::MIN_DIM);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    height_ext = HW'(image_height);
    eff_h = (height_ext < HW'(sgm_pkg::MIN_DIM)) ? HW'(sgm_pkg::MIN_DIM) : height_ext;
  end

  // pixel position counters
  logic [CW-1:0]               col_cnt;
  logic [sgm_pkg::ROW_W-1:0]   row_cnt;
  logic                        in_xfer, line_end, frame_end, has_res;

  assign in_xfer   = s_tvalid && s_tready;
  assign col_plus  = CMP_W'(col_cnt) + CMP_W'(1);
  assign row_plus  = HW'(row_cnt) + HW'(1);
  assign line_end  = (col_plus >= eff_w);
  assign frame_end = line_end && (row_plus >= eff_h);
  assign has_res   = (col_cnt >= CW'(2)) && (row_cnt >= sgm_pkg::ROW_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_xfer) begin
      if (line_end) begin
        col_cnt <= '0;
        row_cnt <= frame_end ? '0 : row_plus[sgm_pkg::ROW_W-1:0];
      end else begin
        col_cnt <= col_plus[CW-1:0];
      end
    end
  end

  // input register stage, aligned with the line memory read
  logic                      s1_valid, s1_res, s1_last;
  logic [PW-1:0]             s1_pix;
  logic [CW-1:0]             s1_col;
  logic [sgm_pkg::ROW_W-1:0] s1_row;
  logic                      out_free, s1_go;

  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && (out_free || !s1_res);
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix  <= s_tdata;
      s1_col  <= col_cnt;
      s1_row  <= row_cnt;
      s1_res  <= has_res;
      s1_last <= frame_end;
    end
  end

  // line memory: upper byte is the line before last, lower byte the previous line
  logic [2*PW-1:0] line_rd;
  logic [PW-1:0]   top_r, mid_r;

  sgm_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data ({mid_r, s1_pix}),
    .rd_en   (in_xfer),
    .rd_addr (col_cnt),
    .rd_data (line_rd)
  );

  assign top_r = line_rd[2*PW-1:PW];
  assign mid_r = line_rd[PW-1:0];

  // window registers: two previous columns of the three rows
  logic [PW-1:0] top_l, top_c, mid_l, mid_c, bot_l, bot_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_l <= '0;
      top_c <= '0;
      mid_l <= '0;
      mid_c <= '0;
      bot_l <= '0;
      bot_c <= '0;
    end else if (s1_go) begin
      top_l <= top_c;
      top_c <= top_r;
      mid_l <= mid_c;
      mid_c <= mid_r;
      bot_l <= bot_c;
      bot_c <= s1_pix;
    end
  end

  // gradient and magnitude
  sgm_pkg::window_t win;
  sgm_pkg::grad_t   grad;

  assign win = '{top_l: top_l, top_c: top_c, top_r: top_r,
                 mid_l: mid_l, mid_r: mid_r,
                 bot_l: bot_l, bot_c: bot_c, bot_r: s1_pix};

  sgm_grad u_grad (
    .win  (win),
    .grad (grad)
  );

  // running frame maximum
  logic [MW-1:0] running_max, running_max_next;

  assign running_max_next = (grad.magnitude > running_max) ? grad.magnitude : running_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        running_max <= '0;
      end else if (s1_res) begin
        running_max <= running_max_next;
      end
    end
  end

  // output register
  logic [CW-1:0] col_m1;
  logic [sgm_pkg::ROW_W-1:0] row_m1;

  assign col_m1 = s1_col - CW'(1);
  assign row_m1 = s1_row - sgm_pkg::ROW_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_res) begin
      m_tdata <= sgm_pkg::OUT_TDATA_W'({running_max_next, grad.magnitude,
                                        grad.grad_y, grad.grad_x, row_m1,
                                        sgm_pkg::COL_W'(col_m1)});
      m_tlast <= s1_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/sgm_checker.sv
// port-level checks for the sobel gradient magnitude unit, bound to the top level
// depends on the top level's port list only
`default_nettype none

module sgm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic        m_tlast
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // the frame maximum includes the current magnitude
  a_max_ge_mag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[65:55] >= m_tdata[54:44])
    else $error("max_magnitude below magnitude");

  // results are interior pixels only
  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:0] != 10'd0) && (m_tdata[21:10] != 12'd0))
    else $error("result on a border pixel");

  // gradients stay within the sobel range
  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[32:22]) >= -1020) && ($signed(m_tdata[32:22]) <= 1020)
              && ($signed(m_tdata[43:33]) >= -1020) && ($signed(m_tdata[43:33]) <= 1020))
    else $error("gradient out of range");

  // magnitude bounded and fill bits zero
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[54:44] <= 11'd1400) && (m_tdata[71:66] == 6'd0))
    else $error("magnitude out of range or fill bits set");

endmodule

bind sobel_gradient_magnitude_unit sgm_checker u_sgm_checker (.*);

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for sobel_gradient_magnitude_unit
// streams raster frames, predicts gradients and frame maxima, and checks every result transfer
// depends on sgm_pkg and sobel_gradient_magnitude_unit
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PIXELS  = 340;

  // one expected result of an interior pixel
  typedef struct {
    logic [sgm_pkg::COL_W-1:0]         column;
    logic [sgm_pkg::ROW_W-1:0]         row;
    logic signed [sgm_pkg::GRAD_W-1:0] grad_x;
    logic signed [sgm_pkg::GRAD_W-1:0] grad_y;
    logic [sgm_pkg::MAG_W-1:0]         magnitude;
    logic [sgm_pkg::MAG_W-1:0]         max_magnitude;
    logic                              frame_last;
  } sobel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [sgm_pkg::PIX_W-1:0]       s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [sgm_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tlast;
  logic                            cfg_we = 1'b0;
  sgm_pkg::cfg_reg_t               cfg_index = sgm_pkg::REG_IMAGE_WIDTH;
  logic [sgm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // stimulus and expectation stores
  logic [sgm_pkg::PIX_W-1:0] pixel_backlog [$];
  sobel_result_t             pending_gradients [$];
  int                        pixels_queued = 0;
  int                        mismatches = 0;
  int                        idle_cycles = 0;

  // predictor state
  logic [sgm_pkg::WIDTH_CFG_W-1:0]  width_reg = sgm_pkg::WIDTH_CFG_W'(sgm_pkg::RESET_WIDTH);
  logic [sgm_pkg::HEIGHT_CFG_W-1:0] height_reg =
    sgm_pkg::HEIGHT_CFG_W'(sgm_pkg::RESET_HEIGHT);
  bit [sgm_pkg::PIX_W-1:0]          prev_line [sgm_pkg::DEFAULT_MAX_WIDTH];
  bit [sgm_pkg::PIX_W-1:0]          older_line [sgm_pkg::DEFAULT_MAX_WIDTH];
  bit [sgm_pkg::PIX_W-1:0]          win [6];
  int                               col_pos = 0;
  int                               row_pos = 0;
  logic [sgm_pkg::MAG_W-1:0]        frame_peak = '0;

  // pacing state of both sides
  int gap_left = 0;
  int stall_left = 0;
  bit feed_steady = 1'b0;
  bit drain_steady = 1'b0;

  sobel_gradient_magnitude_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // pixel[7:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // column, row, grad_x, grad_y, magnitude, max_magnitude, zero fill
    .m_tlast  (m_tlast),    // frame_last
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // effective frame size after saturation
  function automatic int line_length();
    if (width_reg < sgm_pkg::MIN_DIM) return sgm_pkg::MIN_DIM;
    if (width_reg > sgm_pkg::DEFAULT_MAX_WIDTH) return sgm_pkg::DEFAULT_MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int frame_lines();
    if (height_reg < sgm_pkg::MIN_DIM) return sgm_pkg::MIN_DIM;
    return int'(height_reg);
  endfunction

  // advance the window by one pixel and queue the result of an interior centre
  function automatic void compute_gradient(input logic [sgm_pkg::PIX_W-1:0] pix);
    int w, h, c, r;
    int top_l, top_c, top_r, mid_l, mid_r, bot_l, bot_c, bot_r;
    int gx, gy, ax, ay, mn, mag;
    bit line_end, frame_end;
    sobel_result_t res;
    w = line_length();
    h = frame_lines();
    c = col_pos;
    r = row_pos;
    bot_r = int'(pix);
    top_r = int'(older_line[c]);
    mid_r = int'(prev_line[c]);
    top_l = int'(win[0]);
    top_c = int'(win[1]);
    mid_l = int'(win[2]);
    bot_l = int'(win[4]);
    bot_c = int'(win[5]);
    line_end = (c + 1 >= w);
    frame_end = line_end && (r + 1 >= h);
    if (c >= 2 && r >= 2) begin
      gx = (top_r + 2 * mid_r + bot_r) - (top_l + 2 * mid_l + bot_l);
      gy = (bot_l + 2 * bot_c + bot_r) - (top_l + 2 * top_c + top_r);
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      mn = ax < ay ? ax : ay;
      mag = ax + ay - (mn >> 1) - (mn >> 2) + (mn >> 4);
      if (mag > int'(frame_peak)) frame_peak = sgm_pkg::MAG_W'(mag);
      res.column = sgm_pkg::COL_W'(c - 1);
      res.row = sgm_pkg::ROW_W'(r - 1);
      res.grad_x = sgm_pkg::GRAD_W'(gx);
      res.grad_y = sgm_pkg::GRAD_W'(gy);
      res.magnitude = sgm_pkg::MAG_W'(mag);
      res.max_magnitude = frame_peak;
      res.frame_last = frame_end;
      pending_gradients.push_back(res);
    end
    // shift window columns and store the two line histories
    win[0] = win[1];
    win[1] = sgm_pkg::PIX_W'(top_r);
    win[2] = win[3];
    win[3] = sgm_pkg::PIX_W'(mid_r);
    win[4] = win[5];
    win[5] = sgm_pkg::PIX_W'(bot_r);
    older_line[c] = sgm_pkg::PIX_W'(mid_r);
    prev_line[c] = sgm_pkg::PIX_W'(bot_r);
    if (line_end) begin
      col_pos = 0;
      if (frame_end) begin
        row_pos = 0;
        frame_peak = '0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // pause length: mostly none, some short, a few long
  function automatic int pick_pause(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) compute_gradient(s_tdata);
      if ($urandom_range(0, 49) == 0) feed_steady = ~feed_steady;
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          s_tdata <= pixel_backlog.pop_front();
          s_tvalid <= 1'b1;
          gap_left = pick_pause(feed_steady);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready pacing
  always @(posedge clk) begin
    sobel_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_gradients.size() == 0) begin
          $error("result transfer with no result pending");
          mismatches++;
        end else begin
          want = pending_gradients.pop_front();
          compare_field("column", want.column, m_tdata[9:0]);
          compare_field("row", want.row, m_tdata[21:10]);
          compare_field("grad_x", want.grad_x, $signed(m_tdata[32:22]));
          compare_field("grad_y", want.grad_y, $signed(m_tdata[43:33]));
          compare_field("magnitude", want.magnitude, m_tdata[54:44]);
          compare_field("max_magnitude", want.max_magnitude, m_tdata[65:55]);
          compare_field("frame_last", want.frame_last, m_tlast);
        end
      end
      if ($urandom_range(0, 49) == 0) drain_steady = ~drain_steady;
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_pause(drain_steady);
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // wait until every pixel is taken and every result has come
  task automatic settle();
    while (pixel_backlog.size() != 0 || s_tvalid || pending_gradients.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_size(input logic [sgm_pkg::CFG_DATA_W-1:0] width_val,
                              input logic [sgm_pkg::CFG_DATA_W-1:0] height_val);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sgm_pkg::REG_IMAGE_WIDTH;
    cfg_data <= width_val;
    @(posedge clk);
    cfg_index <= sgm_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= height_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = width_val[sgm_pkg::WIDTH_CFG_W-1:0];
    height_reg = height_val[sgm_pkg::HEIGHT_CFG_W-1:0];
  endtask

  // random content with plenty of black and white for strong gradients
  task automatic feed_random(input int count);
    int kind;
    repeat (count) begin
      kind = $urandom_range(0, 3);
      if (kind == 0) pixel_backlog.push_back(8'h00);
      else if (kind == 1) pixel_backlog.push_back(8'hFF);
      else pixel_backlog.push_back(sgm_pkg::PIX_W'($urandom_range(0, 255)));
      pixels_queued++;
    end
  endtask

  // pixels left until the current frame wraps
  task automatic finish_frame();
    int w, h, rest;
    w = line_length();
    h = frame_lines();
    rest = (col_pos + 1 >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) rest += (h - row_pos - 1) * w;
    feed_random(rest);
  endtask

  // 3x3 step patterns in raster order: strong gradients of both signs in x and y
  logic [sgm_pkg::PIX_W-1:0] step_frames [5][9] = '{
    '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF},
    '{8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h7F, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'hFF},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF}
  };

  // stimulus sequence
  initial begin
    int random_start, total, split, sel;
    logic [sgm_pkg::CFG_DATA_W-1:0] wv, hv;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // smallest frames, with width and height below the legal range saturating to three
    for (int f = 0; f < 5; f++) begin
      if (f < 3) program_size(sgm_pkg::CFG_DATA_W'(f), sgm_pkg::CFG_DATA_W'(f));
      else program_size(sgm_pkg::CFG_DATA_W'(sgm_pkg::MIN_DIM),
                        sgm_pkg::CFG_DATA_W'(sgm_pkg::MIN_DIM));
      for (int i = 0; i < 9; i++) begin
        pixel_backlog.push_back(step_frames[f][i]);
        pixels_queued++;
      end
    end

    // size change in the middle of a frame: smaller height and width wrap the counters
    program_size(12'd8, 12'd8);
    feed_random(35);
    program_size(12'd5, 12'd4);
    finish_frame();

    // all width bits set saturate to the widest line, cut short by a narrower width;
    // then all height bits set, cut short by a lower height
    program_size(12'hFFF, 12'd3);
    feed_random(40);
    program_size(12'd3, 12'd3);
    finish_frame();
    program_size(12'd3, 12'hFFF);
    feed_random(30);
    program_size(12'd3, 12'd4);
    finish_frame();

    // random frames, mostly small, some reconfigured part way
    random_start = pixels_queued;
    while (pixels_queued - random_start < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        wv = sgm_pkg::CFG_DATA_W'($urandom_range(0, 2));
        hv = sgm_pkg::CFG_DATA_W'($urandom_range(0, 4));
      end else begin
        wv = {1'($urandom_range(0, 1)), 11'($urandom_range(3, 16))};
        hv = (sel == 1) ? sgm_pkg::CFG_DATA_W'($urandom_range(0, 2))
                        : sgm_pkg::CFG_DATA_W'($urandom_range(3, 8));
      end
      program_size(wv, hv);
      total = line_length() * frame_lines();
      if ($urandom_range(0, 3) == 0) begin
        split = $urandom_range(1, total - 1);
        feed_random(split);
        program_size(sgm_pkg::CFG_DATA_W'($urandom_range(sgm_pkg::MIN_DIM, line_length())),
                     sgm_pkg::CFG_DATA_W'($urandom_range(3, 10)));
        finish_frame();
      end else begin
        feed_random(total);
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_gradients.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
